// ===== rtl/core/tbd_pkg.sv =====
`timescale 1ns / 1ps

package tbd_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_LEADIN = 2'd2;
    localparam logic [1:0] OP_RDERR  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RDERR   = 3'd1;
    localparam logic [2:0] ST_CSUM    = 3'd2;
    localparam logic [2:0] ST_NOBLOCK = 3'd3;
    localparam logic [2:0] ST_EARLY   = 3'd4;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // stray counter covers both the sync hunt and the skip to the duplicate sync
    localparam int STRAY_W = 4;
    localparam logic [STRAY_W-1:0] SKIP_SYNC_LIMIT = 4'd9;

    // one queued request for the back end: a whole block or a single status result
    typedef struct packed {
        logic       emit;
        logic [2:0] status;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

// ===== rtl/core/tbd_cmd_fifo.sv =====
`timescale 1ns / 1ps

module tbd_cmd_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         empty,
    output logic         full
);
    logic [W-1:0] slot_reg [2];
    logic         rd_ptr_reg;
    logic         wr_ptr_reg;
    logic [1:0]   count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/tbd_front.sv =====
`timescale 1ns / 1ps

module tbd_front #(
    parameter int MAX_BLOCK         = 64,
    parameter int SYNC_SEARCH_LIMIT = 8,
    parameter int LEN_W             = 7,
    parameter int ADDR_W            = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [6:0]        s_expected_length,
    input  logic [7:0]        s_symbol_byte,
    input  logic              q_full,
    input  logic              back_busy,
    output logic              push,
    output tbd_pkg::cmd_t     push_cmd,
    output logic [LEN_W-1:0]  push_len,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data
);
    import tbd_pkg::*;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_HUNT     = 3'd1;
    localparam logic [2:0] PH_FILL     = 3'd2;
    localparam logic [2:0] PH_CHECK    = 3'd3;
    localparam logic [2:0] PH_SKIPSYNC = 3'd4;
    localparam logic [2:0] PH_SKIPDATA = 3'd5;

    localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;

    logic [2:0]         phase_reg, phase_next;
    logic               retry_reg, retry_next;
    logic [STRAY_W-1:0] stray_reg, stray_next;
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic [LEN_W-1:0]   target_reg, target_next;
    logic [7:0]         sum_reg, sum_next;
    logic [LEN_W-1:0]   skip_reg, skip_next;
    logic               accept;
    logic [CMP_W-1:0]   len_wide;

    // the store may not change while the back end still reads a block out of it
    assign s_ready = !q_full && !((phase_reg == PH_FILL) && back_busy);
    assign accept  = s_valid && s_ready;
    assign len_wide = CMP_W'(s_expected_length);

    assign wr_addr  = fill_reg[ADDR_W-1:0];
    assign wr_data  = s_symbol_byte;
    assign push_len = target_reg;

    always_comb begin
        phase_next  = phase_reg;
        retry_next  = retry_reg;
        stray_next  = stray_reg;
        fill_next   = fill_reg;
        target_next = target_reg;
        sum_next    = sum_reg;
        skip_next   = skip_reg;
        push        = 1'b0;
        push_cmd    = '{emit: 1'b0, status: ST_OK};
        wr_en       = 1'b0;

        if (accept) begin
            if (s_operation == OP_START) begin
                if (len_wide > CMP_W'(MAX_BLOCK)) begin
                    target_next = LEN_W'(MAX_BLOCK);
                end else begin
                    target_next = LEN_W'(s_expected_length);
                end
                retry_next = 1'b0;
                skip_next  = '0;
                phase_next = PH_HUNT;
                stray_next = '0;
                fill_next  = '0;
                sum_next   = '0;
            end else begin
                case (phase_reg)
                    PH_HUNT: begin
                        if (s_operation == OP_RDERR) begin
                            push       = 1'b1;
                            push_cmd   = '{emit: 1'b0, status: ST_RDERR};
                            phase_next = PH_IDLE;
                        end else if (s_operation == OP_DATA) begin
                            if (s_symbol_byte == SYNC_BYTE) begin
                                fill_next  = '0;
                                sum_next   = '0;
                                stray_next = '0;
                                phase_next = (target_reg == '0) ? PH_CHECK : PH_FILL;
                            end else if (stray_reg >= STRAY_W'(SYNC_SEARCH_LIMIT)) begin
                                push       = 1'b1;
                                push_cmd   = '{emit: 1'b0, status: ST_NOBLOCK};
                                phase_next = PH_IDLE;
                            end else begin
                                stray_next = stray_reg + 1'b1;
                            end
                        end
                    end
                    PH_FILL: begin
                        if (s_operation == OP_RDERR) begin
                            push       = 1'b1;
                            push_cmd   = '{emit: 1'b0, status: ST_RDERR};
                            phase_next = PH_IDLE;
                        end else if (s_operation == OP_LEADIN) begin
                            push       = 1'b1;
                            push_cmd   = '{emit: 1'b0, status: ST_EARLY};
                            phase_next = PH_IDLE;
                        end else begin
                            wr_en     = 1'b1;
                            sum_next  = sum_reg + s_symbol_byte;
                            fill_next = fill_reg + 1'b1;
                            if (fill_next >= target_reg) begin
                                phase_next = PH_CHECK;
                            end
                        end
                    end
                    PH_CHECK: begin
                        if (s_operation == OP_RDERR) begin
                            push       = 1'b1;
                            push_cmd   = '{emit: 1'b0, status: ST_RDERR};
                            phase_next = PH_IDLE;
                        end else if (s_operation == OP_LEADIN || s_symbol_byte != sum_reg) begin
                            if (retry_reg) begin
                                push       = 1'b1;
                                push_cmd   = '{emit: 1'b0, status: ST_CSUM};
                                phase_next = PH_IDLE;
                            end else begin
                                retry_next = 1'b1;
                                phase_next = PH_HUNT;
                                stray_next = '0;
                                fill_next  = '0;
                                sum_next   = '0;
                            end
                        end else begin
                            push     = 1'b1;
                            push_cmd = '{emit: 1'b1, status: ST_OK};
                            if (retry_reg) begin
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_SKIPSYNC;
                                stray_next = '0;
                            end
                        end
                    end
                    PH_SKIPSYNC: begin
                        if (s_operation == OP_DATA && s_symbol_byte == SYNC_BYTE) begin
                            phase_next = PH_SKIPDATA;
                            skip_next  = '0;
                        end else if (stray_reg >= SKIP_SYNC_LIMIT) begin
                            phase_next = PH_SKIPDATA;
                            skip_next  = '0;
                        end else begin
                            stray_next = stray_reg + 1'b1;
                        end
                    end
                    PH_SKIPDATA: begin
                        if (s_operation == OP_RDERR) begin
                            phase_next = PH_IDLE;
                        end else begin
                            // data plus checksum: target + 1 items in all
                            if (skip_reg >= target_reg) begin
                                phase_next = PH_IDLE;
                            end
                            skip_next = skip_reg + 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            retry_reg  <= 1'b0;
            stray_reg  <= '0;
            fill_reg   <= '0;
            target_reg <= '0;
            sum_reg    <= '0;
            skip_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            retry_reg  <= retry_next;
            stray_reg  <= stray_next;
            fill_reg   <= fill_next;
            target_reg <= target_next;
            sum_reg    <= sum_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

// ===== rtl/core/tbd_back.sv =====
`timescale 1ns / 1ps

module tbd_back #(
    parameter int MAX_BLOCK = 64,
    parameter int LEN_W     = 7,
    parameter int ADDR_W    = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              q_empty,
    input  tbd_pkg::cmd_t     q_cmd,
    input  logic [LEN_W-1:0]  q_len,
    output logic              q_pop,
    output logic              busy,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_data_byte,
    output logic              m_byte_valid,
    output logic [2:0]        m_status,
    output logic              m_last
);
    import tbd_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    logic [7:0]        store_mem [MAX_BLOCK];
    logic [7:0]        rd_data_reg;
    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              byte_mode_reg, byte_mode_next;
    logic [2:0]        status_reg, status_next;
    logic              at_end;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (state_reg == B_READ) begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    assign at_end = ((LEN_W'(idx_reg) + 1'b1) == len_reg);

    assign busy         = !q_empty || (state_reg != B_IDLE);
    assign m_valid      = (state_reg == B_OUT);
    assign m_data_byte  = byte_mode_reg ? rd_data_reg : 8'd0;
    assign m_byte_valid = byte_mode_reg;
    assign m_status     = byte_mode_reg ? ST_OK : status_reg;
    assign m_last       = byte_mode_reg ? at_end : 1'b1;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        byte_mode_next = byte_mode_reg;
        status_next    = status_reg;
        q_pop          = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop       = 1'b1;
                    idx_next    = '0;
                    len_next    = q_len;
                    status_next = q_cmd.status;
                    if (q_cmd.emit && q_len != '0) begin
                        byte_mode_next = 1'b1;
                        state_next     = B_READ;
                    end else begin
                        // failures and the empty block give one status result
                        byte_mode_next = 1'b0;
                        state_next     = B_OUT;
                    end
                end
            end
            B_READ: begin
                state_next = B_OUT;
            end
            B_OUT: begin
                if (m_ready) begin
                    if (!byte_mode_reg || at_end) begin
                        state_next = B_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        byte_mode_reg <= byte_mode_next;
        status_reg    <= status_next;
    end

endmodule

// ===== rtl/core/tape_block_deframer_core.sv =====
`timescale 1ns / 1ps
// channel  | ports                                              | direction
// ---------+----------------------------------------------------+----------
// input    | s_valid s_ready s_operation s_expected_length      | in
//          | s_symbol_byte                                      |
// result   | m_valid m_ready m_data_byte m_byte_valid m_status  | out
//          | m_last                                             |
//
// an input request is taken while the command queue has room, save as below;
// the back end picks up a request, then gives each byte by a store read and then
// the output register, and takes no new request until the last result is out.
// reset clears the control state only; the block store is never cleared.
// while the back end is busy (queue not empty or a result pending), every request in the fill phase is held off.

module tape_block_deframer_core #(
    parameter int MAX_BLOCK         = 64,
    parameter int SYNC_SEARCH_LIMIT = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [6:0] s_expected_length,
    input  logic [7:0] s_symbol_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_byte_valid,
    output logic [2:0] m_status,
    output logic       m_last
);
    import tbd_pkg::*;

    localparam int LEN_W  = $clog2(MAX_BLOCK + 1);
    localparam int ADDR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int Q_W    = CMD_W + LEN_W;

    logic              q_full, q_empty, q_push, q_pop, back_busy;
    cmd_t              push_cmd, head_cmd;
    logic [LEN_W-1:0]  push_len, head_len;
    logic [Q_W-1:0]    q_head;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    tbd_front #(
        .MAX_BLOCK        (MAX_BLOCK),
        .SYNC_SEARCH_LIMIT(SYNC_SEARCH_LIMIT),
        .LEN_W            (LEN_W),
        .ADDR_W           (ADDR_W)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_expected_length(s_expected_length),
        .s_symbol_byte    (s_symbol_byte),
        .q_full           (q_full),
        .back_busy        (back_busy),
        .push             (q_push),
        .push_cmd         (push_cmd),
        .push_len         (push_len),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data)
    );

    tbd_cmd_fifo #(
        .W(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({push_cmd, push_len}),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    assign head_cmd = cmd_t'(q_head[Q_W-1:LEN_W]);
    assign head_len = q_head[LEN_W-1:0];

    tbd_back #(
        .MAX_BLOCK(MAX_BLOCK),
        .LEN_W    (LEN_W),
        .ADDR_W   (ADDR_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .q_empty     (q_empty),
        .q_cmd       (head_cmd),
        .q_len       (head_len),
        .q_pop       (q_pop),
        .busy        (back_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_byte_valid(m_byte_valid),
        .m_status    (m_status),
        .m_last      (m_last)
    );

endmodule
